// File: hdl/mwsm_pkg.sv
package mwsm_pkg;

	// Default sizes
	localparam int PAT_MAX_DEF  = 128;
	localparam int TEXT_MAX_DEF = 32768;

	// Field widths of the stream channels
	localparam int ACTION_W   = 2;
	localparam int PIDX_W     = 7;
	localparam int SYM_W      = 8;
	localparam int CFG_W      = 8;
	localparam int OSTART_W   = 15;
	localparam int OLEN_W     = 16;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;

	// Internal position and length widths, wide enough for the largest text
	localparam int POS_W = 16;
	localparam int LEN_W = 17;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD   = 2'd0,
		ACT_TEXT   = 2'd1,
		ACT_END    = 2'd2,
		ACT_UNUSED = 2'd3
	} action_t;

	// Full-match report of the last active cell for one text byte
	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] pos;
	} win_req_t;

endpackage

// File: hdl/min_window_subsequence_matcher.sv
// Channel   Dir  Fields (lowest bit first)                       Request
// --------  ---  ----------------------------------------------  -------------------------
// cfg       in   cfg_wdata: pattern_length[7:0]                   cfg_we high at clk edge
// s_axis    in   tuser: action[1:0]                               tvalid && tready
//                tdata: pattern_index[6:0], symbol[14:7]
// m_axis    out  tdata: found[0], window_start[15:1],             tvalid && tready
//                window_length[31:16], overflow[32]
//
// All pattern cells update together from their left neighbor, so a text byte
// is absorbed in the cycle it is accepted.
// The full-match check against the best window runs one stage behind; an
// end-of-text request folds that pending check in before loading the result.
// s_axis stalls only while a result sits unread in the output register.
// Reset (arst_n low) clears all match cells, counters and the output valid flag;
// pattern bytes are not cleared and read as unknown until loaded.
module min_window_subsequence_matcher #(
	parameter int PAT_MAX  = mwsm_pkg::PAT_MAX_DEF,
	parameter int TEXT_MAX = mwsm_pkg::TEXT_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mwsm_pkg::CFG_W-1:0]        cfg_wdata,      // pattern_length
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [mwsm_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // pattern_index, symbol
	input  logic [mwsm_pkg::ACTION_W-1:0]     s_axis_tuser,   // action
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [mwsm_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // found, window_start,
	                                                          // window_length, overflow
);

	localparam int MW    = $clog2(PAT_MAX + 1);
	localparam int IW    = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
	localparam int CNT_W = $clog2(TEXT_MAX + 1);
	localparam int LOADABLE = (PAT_MAX < (2 ** mwsm_pkg::PIDX_W)) ?
	                          PAT_MAX : (2 ** mwsm_pkg::PIDX_W);

	// Unpack the request
	mwsm_pkg::action_t                 action;
	logic [mwsm_pkg::PIDX_W-1:0]       pidx;
	logic [mwsm_pkg::SYM_W-1:0]        sym;
	logic                              s_acc;
	logic                              load_acc;
	logic                              text_acc;
	logic                              end_acc;
	logic                              text_en;

	assign action = mwsm_pkg::action_t'(s_axis_tuser);
	assign pidx   = s_axis_tdata[mwsm_pkg::PIDX_W-1:0];
	assign sym    = s_axis_tdata[mwsm_pkg::PIDX_W +: mwsm_pkg::SYM_W];

	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign load_acc = s_acc && (action == mwsm_pkg::ACT_LOAD);
	assign text_acc = s_acc && (action == mwsm_pkg::ACT_TEXT);
	assign end_acc  = s_acc && (action == mwsm_pkg::ACT_END);

	// Registers
	logic [MW-1:0]    m_q;          // pattern length in use, already clamped
	logic [CNT_W-1:0] pos_q;
	logic             overflow_q;
	logic             out_valid_q;
	logic             out_found_q;
	logic [mwsm_pkg::OSTART_W-1:0] out_start_q;
	logic [mwsm_pkg::OLEN_W-1:0]   out_len_q;
	logic             out_ovf_q;

	logic             pos_full;
	logic [mwsm_pkg::POS_W-1:0] pos;
	logic [MW-1:0]    m_next;

	assign pos_full = (pos_q >= CNT_W'(TEXT_MAX));
	assign pos      = mwsm_pkg::POS_W'(pos_q);
	assign text_en  = text_acc && !pos_full;

	// Clamp the written length to 1..PAT_MAX; the raw value is never read back
	always_comb begin
		if (cfg_wdata == '0) begin
			m_next = MW'(1);
		end else if (int'(cfg_wdata) > PAT_MAX) begin
			m_next = MW'(PAT_MAX);
		end else begin
			m_next = MW'(cfg_wdata);
		end
	end

	// Row of pattern cells; cell 0 starts a match at the current position
	logic [PAT_MAX-1:0]          cell_valid;
	logic [mwsm_pkg::POS_W-1:0]  cell_start [PAT_MAX];
	logic [PAT_MAX-1:0]          cell_hit;
	logic [mwsm_pkg::POS_W-1:0]  cell_new_start [PAT_MAX];

	genvar j;
	generate
		for (j = 0; j < PAT_MAX; j++) begin : g_cell
			logic                       we;
			logic                       pv;
			logic [mwsm_pkg::POS_W-1:0] ps;

			if (j < LOADABLE) begin : g_ld
				assign we = load_acc && (pidx == mwsm_pkg::PIDX_W'(j));
			end else begin : g_nold
				assign we = 1'b0;
			end

			if (j == 0) begin : g_first
				assign pv = 1'b1;
				assign ps = pos;
			end else begin : g_next
				assign pv = cell_valid[j-1];
				assign ps = cell_start[j-1];
			end

			mwsm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.load_we    (we),
				.text_en    (text_en),
				.active     (MW'(j) < m_q),
				.clear      (end_acc),
				.sym        (sym),
				.prev_valid (pv),
				.prev_start (ps),
				.valid      (cell_valid[j]),
				.start      (cell_start[j]),
				.hit        (cell_hit[j])
			);

			assign cell_new_start[j] = ps;
		end
	endgenerate

	// Pick the last active cell's full-match report
	logic [IW-1:0]        last_idx;
	mwsm_pkg::win_req_t   req;

	assign last_idx  = IW'(m_q - MW'(1));
	assign req.hit   = cell_hit[last_idx];
	assign req.start = cell_new_start[last_idx];
	assign req.pos   = pos;

	logic                       best_found;
	logic [mwsm_pkg::POS_W-1:0] best_start;
	logic [mwsm_pkg::LEN_W-1:0] best_length;

	mwsm_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.clear       (end_acc),
		.found       (best_found),
		.best_start  (best_start),
		.best_length (best_length)
	);

	// Accept while the output register is empty or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q         <= MW'(1);
			pos_q       <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				m_q <= m_next;
			end
			if (end_acc) begin
				// Report, then drop all running state
				pos_q       <= '0;
				overflow_q  <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (text_acc) begin
					if (pos_full) begin
						overflow_q <= 1'b1;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
					end
				end
				if (m_axis_tready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (end_acc) begin
			out_found_q <= best_found;
			out_start_q <= mwsm_pkg::OSTART_W'(best_start);
			out_len_q   <= mwsm_pkg::OLEN_W'(best_length);
			out_ovf_q   <= overflow_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_ovf_q, out_len_q, out_start_q, out_found_q};

endmodule

// File: hdl/mwsm_cell.sv
module mwsm_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load_we,
	input  logic                         text_en,
	input  logic                         active,
	input  logic                         clear,
	input  logic [mwsm_pkg::SYM_W-1:0]   sym,
	input  logic                         prev_valid,
	input  logic [mwsm_pkg::POS_W-1:0]   prev_start,
	output logic                         valid,
	output logic [mwsm_pkg::POS_W-1:0]   start,
	output logic                         hit
);

	logic [mwsm_pkg::SYM_W-1:0] pat_q;
	logic                       valid_q;
	logic [mwsm_pkg::POS_W-1:0] start_q;

	// Extend the neighbor's prefix by this byte
	assign hit = text_en && active && prev_valid && (pat_q == sym);

	always_ff @(posedge clk) begin
		if (load_we) begin
			pat_q <= sym;
		end
		if (hit) begin
			start_q <= prev_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (hit) begin
			valid_q <= 1'b1;
		end
	end

	assign valid = valid_q;
	assign start = start_q;

endmodule

// File: hdl/mwsm_window.sv
module mwsm_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mwsm_pkg::win_req_t         req,
	input  logic                       clear,
	output logic                       found,
	output logic [mwsm_pkg::POS_W-1:0] best_start,
	output logic [mwsm_pkg::LEN_W-1:0] best_length
);

	mwsm_pkg::win_req_t         req_s1;
	logic [mwsm_pkg::LEN_W-1:0] len;
	logic [mwsm_pkg::LEN_W-1:0] len_q;
	logic [mwsm_pkg::POS_W-1:0] start_q;
	logic [mwsm_pkg::LEN_W-1:0] upd_len;
	logic [mwsm_pkg::POS_W-1:0] upd_start;

	assign len = {1'b0, req_s1.pos} - {1'b0, req_s1.start} + mwsm_pkg::LEN_W'(1);

	// Replace only on a strictly shorter window, so ties keep the leftmost
	always_comb begin
		upd_len   = len_q;
		upd_start = start_q;
		if (req_s1.hit && ((len_q == '0) || (len < len_q))) begin
			upd_len   = len;
			upd_start = req_s1.start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1  <= '0;
			len_q   <= '0;
			start_q <= '0;
		end else begin
			req_s1 <= req;
			if (clear) begin
				len_q   <= '0;
				start_q <= '0;
			end else begin
				len_q   <= upd_len;
				start_q <= upd_start;
			end
		end
	end

	assign found       = (upd_len != '0);
	assign best_start  = upd_start;
	assign best_length = upd_len;

endmodule
